[hdl/histogram_inverse_cdf_sampler_assert.svh]
// Assertion macros for the histogram inverse-CDF sampler.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef HISTOGRAM_INVERSE_CDF_SAMPLER_ASSERT_SVH
`define HISTOGRAM_INVERSE_CDF_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define HICS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HICS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HICS_ASSERT_IMP(label, ante, cons, msg)
`define HICS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hdl/hics_pkg.sv]
// Shared constants of the histogram inverse-CDF sampler: item kind codes
// and the fixed field widths. No dependencies.
package hics_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEN_W    = 20;
  localparam int unsigned DIR_W    = 3;
  localparam int unsigned UNI_W    = 16;
  localparam int unsigned VALUE_W  = 16;
  // Lengths are Q16.4: dropping the fraction leaves whole metres to divide.
  localparam int unsigned LEN_FRAC = 4;
  localparam int unsigned DIVD_W   = LEN_W - LEN_FRAC;

  localparam logic [KIND_W-1:0] KIND_ADD_LEN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_DIR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FINALIZE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DRAW_LEN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DRAW_DIR = 3'd4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

endpackage

[hdl/histogram_inverse_cdf_sampler.sv]
// Histogram inverse-CDF sampler: one histogram memory with read-modify-write
// control. Depends on hics_pkg and histogram_inverse_cdf_sampler_assert.svh.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  kind, road_class, edge_length,
//                                               direction_count, uniform_draw
//  out      output     out_valid_o / out_stall_i drawn_value, drawn_valid
//
// One item at a time, paced by the memory port and the walk sequencer.
// Add direction: a read-modify-write; add length: one multiply by the
// reciprocal of the bin width, then a read-modify-write. An add after finalize
// first runs a clearing pass over all 2*NUM_LENGTH_BINS + 2*NUM_DIRECTION_BINS
// entries. Finalize walks the whole memory; a draw walks one histogram. After
// reset the same clearing pass runs with in_stall_o high. A stalled result is
// held in the output register while the next transaction is taken; it only
// delays the finishing of that next one.
`include "histogram_inverse_cdf_sampler_assert.svh"

module histogram_inverse_cdf_sampler #(
  parameter int unsigned NUM_LENGTH_BINS    = 64,
  parameter int unsigned NUM_DIRECTION_BINS = 8,
  parameter int unsigned BIN_WIDTH          = 20,
  parameter int unsigned COUNT_BITS         = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hics_pkg::KIND_W-1:0]   kind_i,
  input  logic                          road_class_i,
  input  logic [hics_pkg::LEN_W-1:0]    edge_length_i,
  input  logic [hics_pkg::DIR_W-1:0]    direction_count_i,
  input  logic [hics_pkg::UNI_W-1:0]    uniform_draw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hics_pkg::VALUE_W-1:0]  drawn_value_o,
  output logic                          drawn_valid_o
);

  // Memory map: length bins of class 0 and 1, then direction bins of both.
  localparam int unsigned MEM_DEPTH = 2 * NUM_LENGTH_BINS + 2 * NUM_DIRECTION_BINS;
  localparam int unsigned DIR_BASE  = 2 * NUM_LENGTH_BINS;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CW        = $clog2(MEM_DEPTH + 1);
  localparam int unsigned NEED_W    = hics_pkg::UNI_W + COUNT_BITS;
  // Division by the bin width is a multiply by a rounded-up reciprocal. The
  // shift keeps enough guard bits for the quotient to be exact on 16 bits.
  localparam int unsigned RECIP_SHIFT = hics_pkg::DIVD_W + $clog2(BIN_WIDTH);
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH;
  localparam int unsigned RECIP_W     = hics_pkg::DIVD_W + 1;
  localparam int unsigned PROD_W      = hics_pkg::DIVD_W + RECIP_W;
  localparam int unsigned BWW       = $clog2(BIN_WIDTH + 1);
  localparam int unsigned CENTRE_W  = CW + BWW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_ADD_RD,
    S_ADD_WR,
    S_WALK,
    S_RESP
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  state_e                        state_q;
  logic [hics_pkg::KIND_W-1:0]   kind_q;
  logic                          cls_q;
  logic [hics_pkg::DIVD_W-1:0]   divx_q;
  logic [hics_pkg::DIVD_W-1:0]   quot_q;
  logic [hics_pkg::DIR_W-1:0]    dirs_q;
  logic [CW-1:0]                 add_addr_q;
  logic [CW-1:0]                 iss_q;
  logic [CW-1:0]                 end_q;
  logic [CW-1:0]                 base_q;
  logic                          dat_v_q;
  logic [CW-1:0]                 dat_addr_q;
  logic [COUNT_BITS-1:0]         acc_q;
  logic [NEED_W-1:0]             need_q;
  logic                          clr_add_q;
  logic [COUNT_BITS-1:0]         class_tot_q [4];
  logic [COUNT_BITS-1:0]         latched_q [4];
  logic                          fin_q;
  logic [hics_pkg::VALUE_W-1:0]  res_value_q;
  logic                          res_valid_q;
  logic                          out_valid_q;
  logic [hics_pkg::VALUE_W-1:0]  drawn_value_q;
  logic                          drawn_valid_q;

  logic [COUNT_BITS-1:0]         hist_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0]         rdata_q;

  logic                          in_accept;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [AW-1:0]                 wr_addr;
  logic [COUNT_BITS-1:0]         wdata;
  logic [PROD_W-1:0]             len_prod;
  logic [CW-1:0]                 len_bin;
  logic [CW-1:0]                 dir_bin;
  logic [CW-1:0]                 add_addr_c;
  logic                          seg_start;
  logic [COUNT_BITS-1:0]         fin_sum;
  logic                          draw_hit;
  logic                          walk_last;
  logic [CW-1:0]                 draw_idx;
  logic [CENTRE_W-1:0]           centre;
  logic [hics_pkg::VALUE_W-1:0]  hit_value;
  logic [1:0]                    acc_tot_idx;
  logic [NEED_W-1:0]             need_d;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign drawn_value_o = drawn_value_q;
  assign drawn_valid_o = drawn_valid_q;

  always_comb begin
    len_prod = PROD_W'(divx_q) * PROD_W'(RECIP);

    len_bin = (32'(quot_q) >= NUM_LENGTH_BINS) ? CW'(NUM_LENGTH_BINS - 1) : CW'(quot_q);
    dir_bin = (32'(dirs_q) >= NUM_DIRECTION_BINS) ? CW'(NUM_DIRECTION_BINS - 1)
                                                  : CW'(dirs_q);
    if (kind_q == hics_pkg::KIND_ADD_LEN) begin
      add_addr_c = (cls_q ? CW'(NUM_LENGTH_BINS) : CW'(0)) + len_bin;
    end else begin
      add_addr_c = CW'(DIR_BASE) + (cls_q ? CW'(NUM_DIRECTION_BINS) : CW'(0)) + dir_bin;
    end

    seg_start = (dat_addr_q == CW'(0)) || (dat_addr_q == CW'(NUM_LENGTH_BINS)) ||
                (dat_addr_q == CW'(DIR_BASE)) ||
                (dat_addr_q == CW'(DIR_BASE + NUM_DIRECTION_BINS));
    fin_sum   = sat_add(seg_start ? '0 : acc_q, rdata_q);
    draw_hit  = (rdata_q > acc_q) && (need_q <= {rdata_q, {hics_pkg::UNI_W{1'b0}}});
    walk_last = (dat_addr_q == end_q - 1'b1);

    draw_idx = dat_addr_q - base_q;
    centre   = CENTRE_W'(draw_idx) * CENTRE_W'(BIN_WIDTH) + CENTRE_W'(BIN_WIDTH / 2);
    if (kind_q == hics_pkg::KIND_DRAW_LEN) begin
      hit_value = (32'(centre) > 32'(hics_pkg::VALUE_MAX)) ? hics_pkg::VALUE_MAX
                                                           : hics_pkg::VALUE_W'(centre);
    end else begin
      hit_value = hics_pkg::VALUE_W'(draw_idx);
    end

    acc_tot_idx = {road_class_i, (kind_i == hics_pkg::KIND_DRAW_DIR)};
    need_d      = NEED_W'(uniform_draw_i) * NEED_W'(latched_q[acc_tot_idx]);

    rd_en   = 1'b0;
    rd_addr = iss_q[AW-1:0];
    mem_we  = 1'b0;
    wr_addr = dat_addr_q[AW-1:0];
    wdata   = fin_sum;
    unique case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = iss_q[AW-1:0];
        wdata   = '0;
      end
      S_ADD_RD: begin
        rd_en   = 1'b1;
        rd_addr = add_addr_c[AW-1:0];
      end
      S_ADD_WR: begin
        mem_we  = 1'b1;
        wr_addr = add_addr_q[AW-1:0];
        wdata   = sat_inc(rdata_q);
      end
      S_WALK: begin
        rd_en  = (iss_q < end_q);
        mem_we = dat_v_q && (kind_q == hics_pkg::KIND_FINALIZE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      iss_q       <= '0;
      clr_add_q   <= 1'b0;
      dat_v_q     <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        class_tot_q[k] <= '0;
        latched_q[k]   <= '0;
      end
    end else begin
      // In S_RESP the output register is reloaded below instead.
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q      <= kind_i;
            cls_q       <= road_class_i;
            divx_q      <= edge_length_i[hics_pkg::LEN_W-1:hics_pkg::LEN_FRAC];
            dirs_q      <= direction_count_i;
            res_value_q <= '0;
            res_valid_q <= 1'b0;
            acc_q       <= '0;
            dat_v_q     <= 1'b0;
            need_q      <= need_d;
            unique case (kind_i)
              hics_pkg::KIND_ADD_LEN, hics_pkg::KIND_ADD_DIR: begin
                iss_q <= '0;
                if (fin_q) begin
                  // Adding after finalize starts a fresh collection.
                  fin_q     <= 1'b0;
                  clr_add_q <= 1'b1;
                  state_q   <= S_CLEAR;
                  for (int k = 0; k < 4; k++) begin
                    class_tot_q[k] <= '0;
                    latched_q[k]   <= '0;
                  end
                end else if (kind_i == hics_pkg::KIND_ADD_LEN) begin
                  state_q <= S_DIV;
                end else begin
                  state_q <= S_ADD_RD;
                end
              end
              hics_pkg::KIND_FINALIZE: begin
                iss_q   <= '0;
                end_q   <= CW'(MEM_DEPTH);
                base_q  <= '0;
                state_q <= fin_q ? S_RESP : S_WALK;
              end
              hics_pkg::KIND_DRAW_LEN: begin
                base_q  <= road_class_i ? CW'(NUM_LENGTH_BINS) : CW'(0);
                iss_q   <= road_class_i ? CW'(NUM_LENGTH_BINS) : CW'(0);
                end_q   <= road_class_i ? CW'(2 * NUM_LENGTH_BINS) : CW'(NUM_LENGTH_BINS);
                state_q <= fin_q ? S_WALK : S_RESP;
              end
              hics_pkg::KIND_DRAW_DIR: begin
                base_q  <= CW'(DIR_BASE) + (road_class_i ? CW'(NUM_DIRECTION_BINS) : CW'(0));
                iss_q   <= CW'(DIR_BASE) + (road_class_i ? CW'(NUM_DIRECTION_BINS) : CW'(0));
                end_q   <= road_class_i ? CW'(MEM_DEPTH)
                                        : CW'(DIR_BASE + NUM_DIRECTION_BINS);
                state_q <= fin_q ? S_WALK : S_RESP;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_CLEAR: begin
          iss_q <= iss_q + 1'b1;
          if (iss_q == CW'(MEM_DEPTH - 1)) begin
            clr_add_q <= 1'b0;
            if (!clr_add_q) begin
              state_q <= S_IDLE;
            end else if (kind_q == hics_pkg::KIND_ADD_LEN) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_ADD_RD;
            end
          end
        end
        S_DIV: begin
          quot_q  <= hics_pkg::DIVD_W'(len_prod >> RECIP_SHIFT);
          state_q <= S_ADD_RD;
        end
        S_ADD_RD: begin
          add_addr_q <= add_addr_c;
          state_q    <= S_ADD_WR;
        end
        S_ADD_WR: begin
          class_tot_q[{cls_q, (kind_q == hics_pkg::KIND_ADD_DIR)}] <=
            sat_inc(class_tot_q[{cls_q, (kind_q == hics_pkg::KIND_ADD_DIR)}]);
          state_q <= S_RESP;
        end
        S_WALK: begin
          if (rd_en) begin
            iss_q <= iss_q + 1'b1;
          end
          dat_v_q    <= rd_en;
          dat_addr_q <= iss_q;
          if (dat_v_q) begin
            if (kind_q == hics_pkg::KIND_FINALIZE) begin
              acc_q <= fin_sum;
              if (walk_last) begin
                fin_q   <= 1'b1;
                state_q <= S_RESP;
                for (int k = 0; k < 4; k++) begin
                  latched_q[k]   <= class_tot_q[k];
                  class_tot_q[k] <= '0;
                end
              end
            end else begin
              // acc_q holds the cumulative count of the bin before.
              acc_q <= rdata_q;
              if (draw_hit) begin
                res_value_q <= hit_value;
                res_valid_q <= 1'b1;
                state_q     <= S_RESP;
              end else if (walk_last) begin
                state_q <= S_RESP;
              end
            end
          end
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            drawn_value_q <= res_value_q;
            drawn_valid_q <= res_valid_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `HICS_ASSERT_IMP(a_novalid_zero, out_valid_o && !drawn_valid_o, drawn_value_o == '0, "stray value")
  `HICS_ASSERT_IMP(a_port_conflict, mem_we && rd_en, wr_addr != rd_addr, "port conflict")
  `HICS_ASSERT_IMP(a_hit_needs_fin, (state_q == S_RESP) && res_valid_q, fin_q, "hit unfinalized")
  `HICS_ASSERT_NXT(a_busy_after_accept, in_accept, in_stall_o, "taken while busy")

endmodule

[verif/hics_scoreboard_pkg.sv]
// Scoreboard for the histogram inverse-CDF sampler testbench: a bit-true
// predictor of the histograms and draws, and a queue of expected results.
// Depends on hics_pkg.
package hics_scoreboard_pkg;
  import hics_pkg::*;

  // These match the parameters that the testbench gives the block.
  localparam int unsigned LEN_BINS = 64;
  localparam int unsigned DIR_BINS = 8;
  localparam int unsigned BIN_W    = 20;
  localparam int unsigned CNT_BITS = 20;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // Kind codes that the block does not define.
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hit;
  } draw_result_t;

  class sampler_scoreboard;
    logic [CNT_BITS-1:0] len_hist [2][LEN_BINS];
    logic [CNT_BITS-1:0] dir_hist [2][DIR_BINS];
    logic [CNT_BITS-1:0] run_total [4];
    logic [CNT_BITS-1:0] held_total [4];
    bit                  cumulative;
    draw_result_t        pending [$];
    int unsigned         mismatches;

    function new();
      clear_all();
      mismatches = 0;
    endfunction

    function void clear_all();
      foreach (len_hist[c, b]) len_hist[c][b] = '0;
      foreach (dir_hist[c, b]) dir_hist[c][b] = '0;
      foreach (run_total[k]) begin
        run_total[k]  = '0;
        held_total[k] = '0;
      end
      cumulative = 1'b0;
    endfunction

    function logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function logic [CNT_BITS-1:0] sum_sat(logic [CNT_BITS-1:0] a, logic [CNT_BITS-1:0] b);
      logic [CNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
    endfunction

    // First bin that is non-empty and whose cumulative count, scaled by 2^16,
    // reaches u * total, or -1 when there is none.
    function int find_bin(logic [CNT_BITS-1:0] row [], logic [CNT_BITS-1:0] total,
                          logic [UNI_W-1:0] u);
      logic [63:0]         need;
      logic [CNT_BITS-1:0] prev;
      need = 64'(u) * 64'(total);
      prev = '0;
      foreach (row[i]) begin
        if (row[i] > prev && need <= (64'(row[i]) << 16)) return i;
        prev = row[i];
      end
      return -1;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic cls, logic [LEN_W-1:0] len,
                            logic [DIR_W-1:0] dirs, logic [UNI_W-1:0] u);
      draw_result_t        r;
      int                  bin;
      int                  slot;
      int unsigned         centre;
      logic [CNT_BITS-1:0] acc;
      logic [CNT_BITS-1:0] row [];
      r    = '0;
      slot = 2 * int'(cls);
      case (kind)
        KIND_ADD_LEN, KIND_ADD_DIR: begin
          if (cumulative) clear_all();
          if (kind == KIND_ADD_LEN) begin
            bin = int'(len / (BIN_W << LEN_FRAC));
            if (bin >= LEN_BINS) bin = LEN_BINS - 1;
            len_hist[cls][bin] = bump(len_hist[cls][bin]);
            run_total[slot]    = bump(run_total[slot]);
          end else begin
            bin = int'(dirs);
            if (bin >= DIR_BINS) bin = DIR_BINS - 1;
            dir_hist[cls][bin]  = bump(dir_hist[cls][bin]);
            run_total[slot + 1] = bump(run_total[slot + 1]);
          end
        end
        KIND_FINALIZE: begin
          if (!cumulative) begin
            for (int c = 0; c < 2; c++) begin
              acc = '0;
              for (int b = 0; b < LEN_BINS; b++) begin
                acc = sum_sat(acc, len_hist[c][b]);
                len_hist[c][b] = acc;
              end
              acc = '0;
              for (int b = 0; b < DIR_BINS; b++) begin
                acc = sum_sat(acc, dir_hist[c][b]);
                dir_hist[c][b] = acc;
              end
            end
            foreach (run_total[k]) begin
              held_total[k] = run_total[k];
              run_total[k]  = '0;
            end
            cumulative = 1'b1;
          end
        end
        KIND_DRAW_LEN: begin
          if (cumulative) begin
            row = new[LEN_BINS];
            foreach (row[i]) row[i] = len_hist[cls][i];
            bin = find_bin(row, held_total[slot], u);
            if (bin >= 0) begin
              centre  = bin * BIN_W + BIN_W / 2;
              r.value = (centre > VALUE_MAX) ? VALUE_MAX : centre[VALUE_W-1:0];
              r.hit   = 1'b1;
            end
          end
        end
        KIND_DRAW_DIR: begin
          if (cumulative) begin
            row = new[DIR_BINS];
            foreach (row[i]) row[i] = dir_hist[cls][i];
            bin = find_bin(row, held_total[slot + 1], u);
            if (bin >= 0) begin
              r.value = VALUE_W'(bin);
              r.hit   = 1'b1;
            end
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic hit);
      draw_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result transaction: value %0d valid %0b", value, hit);
        return;
      end
      want = pending.pop_front();
      if (value !== want.value || hit !== want.hit) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected value %0d valid %0b, got value %0d valid %0b",
                   want.value, want.hit, value, hit);
      end
    endfunction
  endclass

endpackage

[verif/tb.sv]
// Top of the histogram inverse-CDF sampler testbench: clock, reset, bursty
// stimulus, a stalling receiver and a watchdog. Depends on hics_pkg,
// hics_scoreboard_pkg and the histogram_inverse_cdf_sampler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hics_pkg::*;
  import hics_scoreboard_pkg::*;

  localparam int unsigned ITEM_TARGET = 450;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN       = 300;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i;
  logic               road_class_i;
  logic [LEN_W-1:0]   edge_length_i;
  logic [DIR_W-1:0]   direction_count_i;
  logic [UNI_W-1:0]   uniform_draw_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [VALUE_W-1:0] drawn_value_o;
  logic               drawn_valid_o;

  sampler_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  histogram_inverse_cdf_sampler #(
    .NUM_LENGTH_BINS   (LEN_BINS),
    .NUM_DIRECTION_BINS(DIR_BINS),
    .BIN_WIDTH         (BIN_W),
    .COUNT_BITS        (CNT_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .road_class_i     (road_class_i),
    .edge_length_i    (edge_length_i),
    .direction_count_i(direction_count_i),
    .uniform_draw_i   (uniform_draw_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drawn_value_o    (drawn_value_o),
    .drawn_valid_o    (drawn_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Most lengths land inside the histogram; some use the whole field.
  function automatic logic [LEN_W-1:0] rnd_len();
    if ($urandom_range(0, 4) == 0) return LEN_W'($urandom);
    return LEN_W'($urandom_range(0, LEN_BINS * (BIN_W << LEN_FRAC) - 1));
  endfunction

  function automatic logic [UNI_W-1:0] rnd_u();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return UNI_W'($urandom);
  endfunction

  task automatic issue(logic [KIND_W-1:0] kind, logic cls, logic [LEN_W-1:0] len,
                       logic [DIR_W-1:0] dirs, logic [UNI_W-1:0] u);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    kind_i            = kind;
    road_class_i      = cls;
    edge_length_i     = len;
    direction_count_i = dirs;
    uniform_draw_i    = u;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic issue_spare();
    issue(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), 1'($urandom),
          rnd_len(), DIR_W'($urandom), rnd_u());
  endtask

  task automatic run_directed();
    // Draws before any finalize, then a finalize of an empty store.
    issue(KIND_DRAW_LEN, 1'b0, rnd_len(), DIR_W'($urandom), '0);
    issue(KIND_DRAW_DIR, 1'b1, rnd_len(), DIR_W'($urandom), '1);
    issue(KIND_FINALIZE, 1'b0, rnd_len(), DIR_W'($urandom), rnd_u());
    issue(KIND_FINALIZE, 1'b1, rnd_len(), DIR_W'($urandom), rnd_u());
    issue(KIND_DRAW_LEN, 1'b0, rnd_len(), DIR_W'($urandom), UNI_W'(1 << (UNI_W - 1)));
    // This add clears the finalized store first.
    issue(KIND_ADD_LEN, 1'b0, '0, DIR_W'($urandom), rnd_u());
    issue(KIND_ADD_LEN, 1'b0, '1, DIR_W'($urandom), rnd_u());
    issue(KIND_ADD_LEN, 1'b1, LEN_W'((BIN_W << LEN_FRAC) - 1), DIR_W'($urandom), rnd_u());
    issue(KIND_ADD_LEN, 1'b1, LEN_W'(BIN_W << LEN_FRAC), DIR_W'($urandom), rnd_u());
    issue(KIND_ADD_DIR, 1'b0, rnd_len(), '0, rnd_u());
    issue(KIND_ADD_DIR, 1'b0, rnd_len(), '1, rnd_u());
    issue(KIND_ADD_DIR, 1'b1, rnd_len(), DIR_W'(3), rnd_u());
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      issue(KIND_W'(k), 1'($urandom), rnd_len(), DIR_W'($urandom), rnd_u());
    issue(KIND_FINALIZE, 1'b0, rnd_len(), DIR_W'($urandom), rnd_u());
    issue(KIND_DRAW_LEN, 1'b0, rnd_len(), DIR_W'($urandom), '0);
    issue(KIND_DRAW_LEN, 1'b0, rnd_len(), DIR_W'($urandom), '1);
    issue(KIND_DRAW_LEN, 1'b1, rnd_len(), DIR_W'($urandom), UNI_W'(1 << (UNI_W - 1)));
    issue(KIND_DRAW_DIR, 1'b0, rnd_len(), DIR_W'($urandom), '0);
    issue(KIND_DRAW_DIR, 1'b0, rnd_len(), DIR_W'($urandom), '1);
    issue(KIND_DRAW_DIR, 1'b1, rnd_len(), DIR_W'($urandom), UNI_W'(1));
    issue(KIND_FINALIZE, 1'b1, rnd_len(), DIR_W'($urandom), rnd_u());
    issue(KIND_ADD_DIR, 1'b1, rnd_len(), DIR_W'(5), rnd_u());
  endtask

  // Mostly fill, finalize, draw; sometimes the finalize is left out or doubled.
  task automatic run_random();
    int unsigned       n_adds;
    int unsigned       n_draws;
    logic [KIND_W-1:0] k;
    while (items_sent < ITEM_TARGET) begin
      n_adds = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      repeat (n_adds) begin
        if (items_sent >= ITEM_TARGET) break;
        if ($urandom_range(0, 19) == 0) begin
          issue_spare();
        end else begin
          k = $urandom_range(0, 1) ? KIND_ADD_DIR : KIND_ADD_LEN;
          issue(k, 1'($urandom), rnd_len(), DIR_W'($urandom), rnd_u());
        end
      end
      if ($urandom_range(0, 7) != 0) begin
        issue(KIND_FINALIZE, 1'($urandom), rnd_len(), DIR_W'($urandom), rnd_u());
        if ($urandom_range(0, 9) == 0) begin
          issue(KIND_FINALIZE, 1'($urandom), rnd_len(), DIR_W'($urandom), rnd_u());
        end
      end
      n_draws = $urandom_range(1, 25);
      repeat (n_draws) begin
        if (items_sent >= ITEM_TARGET) break;
        if ($urandom_range(0, 19) == 0) begin
          issue_spare();
        end else begin
          k = $urandom_range(0, 1) ? KIND_DRAW_DIR : KIND_DRAW_LEN;
          issue(k, 1'($urandom), rnd_len(), DIR_W'($urandom), rnd_u());
        end
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    kind_i            = KIND_ADD_LEN;
    road_class_i      = 1'b0;
    edge_length_i     = '0;
    direction_count_i = '0;
    uniform_draw_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // Any stray result after the last expected one would show up here.
    repeat (DRAIN) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The receiver changes its stall behaviour every so often.
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(STALL_NONE, STALL_PERIODIC));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        STALL_NONE:     out_stall_i = 1'b0;
        STALL_LIGHT:    out_stall_i = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall_i = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall_i = ((tick % 5) < 2);
        default:        out_stall_i = 1'b0;
      endcase
    end
  end

  // Both channels are observed in one process, the input before the output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_item(kind_i, road_class_i, edge_length_i, direction_count_i, uniform_draw_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(drawn_value_o, drawn_valid_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

[histogram_inverse_cdf_sampler.f]
+incdir+hdl
hdl/hics_pkg.sv
hdl/histogram_inverse_cdf_sampler.sv
verif/hics_scoreboard_pkg.sv
verif/tb.sv
